// ===== rtl/core/dtfb_pkg.sv =====
`timescale 1ns / 1ps
// Shared definitions for the dirty-tracked LCD frame store.
// Operation codes, default geometry and the store write-control struct.
package dtfb_pkg;

  localparam int DEF_WIDTH_COLUMNS = 128;
  localparam int DEF_PAGE_COUNT    = 8;
  localparam int DEF_HALF_COLUMNS  = 64;
  localparam int DEF_STORE_DEPTH   = DEF_WIDTH_COLUMNS * DEF_PAGE_COUNT;

  localparam logic [7:0] FILL_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    OP_SET_PIXEL = 2'd0,
    OP_FLUSH     = 2'd1,
    OP_FILL      = 2'd2,
    OP_CLEAR     = 2'd3
  } dtfb_op_t;

  typedef struct packed {
    logic pix_we;
    logic dty_we;
    logic dty_d;
  } dtfb_wr_t;

endpackage

// ===== rtl/core/dtfb_store.sv =====
`timescale 1ns / 1ps
// Pixel byte memory and dirty-bit memory, one shared write port, one read port.
// Read data is registered. Depends on dtfb_pkg.
module dtfb_store import dtfb_pkg::*; #(
  parameter int DEPTH = DEF_STORE_DEPTH
) (
  input  logic                     clk,
  input  dtfb_wr_t                 wr_ctl,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_pix,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_pix,
  output logic                     rd_dty
);

  logic [7:0] pix_mem [DEPTH];
  logic       dty_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_ctl.pix_we) begin
      pix_mem[wr_addr] <= wr_pix;
    end
    if (wr_ctl.dty_we) begin
      dty_mem[wr_addr] <= wr_ctl.dty_d;
    end
    rd_pix <= pix_mem[rd_addr];
    rd_dty <= dty_mem[rd_addr];
  end

endmodule

// ===== rtl/core/dirty_tracked_lcd_framebuffer_core.sv =====
`timescale 1ns / 1ps
// Set pixel: busy after the transaction while the byte is read, then written back; busy stays low if ignored.
// Flush step: after the transaction the scan skips clean entries with dirty-bit reads,
// one store entry per cycle, and strobes a result; a done result is followed by a clear
// sweep of the whole store. Fill and clear sweep the whole store as well.
// After reset the store is swept clear (busy high).
// The receiver cannot stall; each result is strobed by out_valid for one cycle.
module dirty_tracked_lcd_framebuffer_core import dtfb_pkg::*; #(
  parameter int WIDTH_COLUMNS = DEF_WIDTH_COLUMNS,
  parameter int PAGE_COUNT    = DEF_PAGE_COUNT,
  parameter int HALF_COLUMNS  = DEF_HALF_COLUMNS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_x_coord,
  input  logic [6:0] in_y_coord,
  input  logic       in_pixel_on,
  output logic       out_valid,
  output logic       out_controller,
  output logic [5:0] out_column,
  output logic [2:0] out_page,
  output logic [7:0] out_pixel_byte,
  output logic       out_done_res
);

  localparam int SIZE  = WIDTH_COLUMNS * PAGE_COUNT;
  localparam int IDX_W = $clog2(SIZE);
  localparam int PTR_W = $clog2(SIZE + 1);
  localparam int PG_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int HC_W  = (HALF_COLUMNS > 1) ? $clog2(HALF_COLUMNS) : 1;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_SCAN
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] swp_r;
  logic [7:0]       swp_pix_r;
  logic             swp_dty_we_r;
  logic             swp_dty_d_r;
  logic [IDX_W-1:0] pidx_r;
  logic [2:0]       pbit_r;
  logic             pon_r;
  logic [PTR_W-1:0] sp_idx_r;
  logic [PG_W-1:0]  sp_pg_r;
  logic [HC_W-1:0]  sp_hc_r;
  logic             sp_hf_r;
  logic             chk_vld_r;
  logic [PG_W-1:0]  chk_pg_r;
  logic [HC_W-1:0]  chk_hc_r;
  logic             chk_hf_r;
  logic             out_valid_r;
  logic             out_ctl_r;
  logic [5:0]       out_col_r;
  logic [2:0]       out_pg_r;
  logic [7:0]       out_byte_r;
  logic             out_done_r;

  dtfb_op_t         op;
  logic             coord_ok;
  logic [7:0]       col_m1;
  logic [6:0]       row_m1;
  logic [IDX_W-1:0] set_idx;
  logic [7:0]       bit_mask;
  dtfb_wr_t         wr_ctl;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_pix;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_pix;
  logic             rd_dty;
  logic             accept;

  assign op       = dtfb_op_t'(in_operation);
  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);
  assign col_m1   = in_x_coord - 8'd1;
  assign row_m1   = in_y_coord - 7'd1;
  assign coord_ok = (in_x_coord != 8'd0) && (32'(in_x_coord) <= 32'(WIDTH_COLUMNS)) &&
                    (in_y_coord != 7'd0) && (32'(in_y_coord) <= 32'(PAGE_COUNT * 8));
  assign set_idx  = IDX_W'(32'(col_m1) * 32'(PAGE_COUNT) + 32'(row_m1[6:3]));
  assign bit_mask = 8'd1 << pbit_r;

  always_comb begin
    wr_ctl  = '0;
    wr_addr = pidx_r;
    wr_pix  = rd_pix;
    rd_addr = pidx_r;
    case (state_r)
      ST_CLR: begin
        wr_ctl.pix_we = 1'b1;
        wr_ctl.dty_we = swp_dty_we_r;
        wr_ctl.dty_d  = swp_dty_d_r;
        wr_addr       = swp_r;
        wr_pix        = swp_pix_r;
      end
      ST_PIX_WR: begin
        wr_ctl.pix_we = 1'b1;
        wr_ctl.dty_we = 1'b1;
        wr_ctl.dty_d  = 1'b1;
        wr_pix        = pon_r ? (rd_pix | bit_mask) : (rd_pix & ~bit_mask);
      end
      ST_SCAN: begin
        rd_addr = sp_idx_r[IDX_W-1:0];
      end
      default: begin
        wr_ctl = '0;
      end
    endcase
  end

  dtfb_store #(
    .DEPTH(SIZE)
  ) u_store (
    .clk    (clk),
    .wr_ctl (wr_ctl),
    .wr_addr(wr_addr),
    .wr_pix (wr_pix),
    .rd_addr(rd_addr),
    .rd_pix (rd_pix),
    .rd_dty (rd_dty)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      swp_r        <= '0;
      swp_pix_r    <= '0;
      swp_dty_we_r <= 1'b1;
      swp_dty_d_r  <= 1'b0;
      sp_idx_r     <= '0;
      sp_pg_r      <= '0;
      sp_hc_r      <= '0;
      sp_hf_r      <= 1'b0;
      chk_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_CLR: begin
          swp_r <= swp_r + 1'b1;
          if (swp_r == IDX_W'(SIZE - 1)) begin
            swp_r   <= '0;
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (op)
              OP_SET_PIXEL: begin
                pidx_r <= set_idx;
                pbit_r <= row_m1[2:0];
                pon_r  <= in_pixel_on;
                if (coord_ok) begin
                  state_r <= ST_PIX_RD;
                end
              end
              OP_FLUSH: begin
                chk_vld_r <= 1'b0;
                state_r   <= ST_SCAN;
              end
              OP_FILL: begin
                swp_r        <= '0;
                swp_pix_r    <= FILL_BYTE;
                swp_dty_we_r <= 1'b1;
                swp_dty_d_r  <= 1'b1;
                state_r      <= ST_CLR;
              end
              default: begin
                swp_r        <= '0;
                swp_pix_r    <= '0;
                swp_dty_we_r <= 1'b0;
                swp_dty_d_r  <= 1'b0;
                state_r      <= ST_CLR;
              end
            endcase
          end
        end
        ST_PIX_RD: begin
          state_r <= ST_PIX_WR;
        end
        ST_PIX_WR: begin
          state_r <= ST_IDLE;
        end
        ST_SCAN: begin
          if (chk_vld_r && rd_dty) begin
            out_valid_r <= 1'b1;
            out_ctl_r   <= chk_hf_r;
            out_col_r   <= 6'(chk_hc_r);
            out_pg_r    <= 3'(chk_pg_r);
            out_byte_r  <= rd_pix;
            out_done_r  <= 1'b0;
            chk_vld_r   <= 1'b0;
            state_r     <= ST_IDLE;
          end else if (sp_idx_r == PTR_W'(SIZE)) begin
            // nothing dirty ahead: report done and wipe everything
            out_valid_r  <= 1'b1;
            out_ctl_r    <= 1'b0;
            out_col_r    <= '0;
            out_pg_r     <= '0;
            out_byte_r   <= '0;
            out_done_r   <= 1'b1;
            chk_vld_r    <= 1'b0;
            sp_idx_r     <= '0;
            sp_pg_r      <= '0;
            sp_hc_r      <= '0;
            sp_hf_r      <= 1'b0;
            swp_r        <= '0;
            swp_pix_r    <= '0;
            swp_dty_we_r <= 1'b1;
            swp_dty_d_r  <= 1'b0;
            state_r      <= ST_CLR;
          end else begin
            chk_vld_r <= 1'b1;
            chk_pg_r  <= sp_pg_r;
            chk_hc_r  <= sp_hc_r;
            chk_hf_r  <= sp_hf_r;
            sp_idx_r  <= sp_idx_r + 1'b1;
            if (sp_pg_r == PG_W'(PAGE_COUNT - 1)) begin
              sp_pg_r <= '0;
              if (sp_hc_r == HC_W'(HALF_COLUMNS - 1)) begin
                sp_hc_r <= '0;
                sp_hf_r <= ~sp_hf_r;
              end else begin
                sp_hc_r <= sp_hc_r + 1'b1;
              end
            end else begin
              sp_pg_r <= sp_pg_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_controller = out_ctl_r;
  assign out_column     = out_col_r;
  assign out_page       = out_pg_r;
  assign out_pixel_byte = out_byte_r;
  assign out_done_res   = out_done_r;

`ifndef SYNTHESIS
  a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_SCAN))
    else $error("result strobe without a flush scan");

  a_done_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> (state_r == ST_CLR && sp_idx_r == '0))
    else $error("done result did not start the clear sweep");

  a_cmd_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation != OP_SET_PIXEL) |=> busy)
    else $error("flush, fill or clear transaction did not raise busy");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sp_idx_r) <= 32'(SIZE))
    else $error("scan pointer past the end of the store");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dirty_tracked_lcd_framebuffer_core (start/busy command port).
// A scoreboard class keeps its own copy of the page store and predicts every flush result.
// Depends on dtfb_pkg and the core RTL.
module tb;
  import dtfb_pkg::*;

  localparam int COLS         = DEF_WIDTH_COLUMNS;
  localparam int PAGES        = DEF_PAGE_COUNT;
  localparam int HALF         = DEF_HALF_COLUMNS;
  localparam int DEPTH        = DEF_STORE_DEPTH;
  localparam int ROWS         = PAGES * 8;
  localparam int RANDOM_ITEMS = 580;
  localparam int CYCLE_LIMIT  = 20_000_000;

  typedef struct packed {
    logic       controller;
    logic [5:0] column;
    logic [2:0] page;
    logic [7:0] pixel_byte;
    logic       done_res;
  } flush_res_t;

  class frame_scoreboard;
    logic [7:0] pixels [DEPTH];
    bit         dirty [DEPTH];
    int         scan_pos;
    flush_res_t flush_q [$];
    int         mismatches;

    function new();
      wipe();
      mismatches = 0;
    endfunction

    function void wipe();
      foreach (pixels[i]) begin
        pixels[i] = '0;
        dirty[i]  = 1'b0;
      end
      scan_pos = 0;
    endfunction

    function void flush_step();
      flush_res_t r;
      int col;
      r = '0;
      for (int i = scan_pos; i < DEPTH; i++) begin
        if (dirty[i]) begin
          col          = i / PAGES;
          r.controller = 1'((col / HALF) % 2);
          r.column     = 6'(col % HALF);
          r.page       = 3'(i % PAGES);
          r.pixel_byte = pixels[i];
          flush_q.push_back(r);
          scan_pos = i + 1;
          return;
        end
      end
      wipe();
      r.done_res = 1'b1;
      flush_q.push_back(r);
    endfunction

    function void note_input(dtfb_op_t op, logic [7:0] x, logic [6:0] y, logic on);
      int xi, yi, idx;
      xi = x;
      yi = y;
      case (op)
        OP_SET_PIXEL: begin
          if (xi >= 1 && xi <= COLS && yi >= 1 && yi <= ROWS) begin
            idx = (xi - 1) * PAGES + (yi - 1) / 8;
            dirty[idx] = 1'b1;
            pixels[idx][(yi - 1) % 8] = on;
          end
        end
        OP_FLUSH: flush_step();
        OP_FILL: begin
          foreach (pixels[i]) begin
            pixels[i] = FILL_BYTE;
            dirty[i]  = 1'b1;
          end
        end
        default: begin
          foreach (pixels[i]) pixels[i] = '0;
        end
      endcase
    endfunction

    // flush transactions still needed to reach the done marker
    function int flushes_to_done();
      int n;
      n = 1;
      for (int i = scan_pos; i < DEPTH; i++) if (dirty[i]) n++;
      return n;
    endfunction

    function string fmt(flush_res_t r);
      return $sformatf("ctl=%0d col=%0d page=%0d byte=%02h done=%0d",
                       r.controller, r.column, r.page, r.pixel_byte, r.done_res);
    endfunction

    function void check_result(flush_res_t got);
      flush_res_t want;
      if (flush_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected result: %s", $time, fmt(got));
        return;
      end
      want = flush_q.pop_front();
      if (got.controller !== want.controller || got.column !== want.column ||
          got.page !== want.page || got.pixel_byte !== want.pixel_byte ||
          got.done_res !== want.done_res) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected %s, got %s", $time, fmt(want), fmt(got));
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [1:0] in_operation = '0;
  logic [7:0] in_x_coord = '0;
  logic [6:0] in_y_coord = '0;
  logic       in_pixel_on = 1'b0;
  logic       busy;
  logic       out_valid;
  logic       out_controller;
  logic [5:0] out_column;
  logic [2:0] out_page;
  logic [7:0] out_pixel_byte;
  logic       out_done_res;

  frame_scoreboard board = new();
  int cycle_count = 0;
  int burst_left  = 0;
  int items_sent  = 0;

  dirty_tracked_lcd_framebuffer_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_pixel_on    (in_pixel_on),
    .out_valid      (out_valid),
    .out_controller (out_controller),
    .out_column     (out_column),
    .out_page       (out_page),
    .out_pixel_byte (out_pixel_byte),
    .out_done_res   (out_done_res)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy)
      board.note_input(dtfb_op_t'(in_operation), in_x_coord, in_y_coord, in_pixel_on);
    if (rst_n && out_valid)
      board.check_result(flush_res_t'({out_controller, out_column, out_page,
                                       out_pixel_byte, out_done_res}));
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_item(dtfb_op_t op, logic [7:0] x, logic [6:0] y, logic on);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(40, 90))
                                               : int'($urandom_range(1, 20));
    end
    burst_left--;
    start        <= 1'b1;
    in_operation <= op;
    in_x_coord   <= x;
    in_y_coord   <= y;
    in_pixel_on  <= on;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_flush();
    send_item(OP_FLUSH, 8'($urandom), 7'($urandom), 1'($urandom));
  endtask

  task automatic drain_to_done();
    int n;
    n = board.flushes_to_done();
    repeat (n) send_flush();
  endtask

  function automatic int near(int base, int span, int hi);
    int v;
    v = base + int'($urandom_range(0, 2 * span)) - span;
    if (v < 1) v = 1;
    if (v > hi) v = hi;
    return v;
  endfunction

  int kind, n, bx, by, cnt;

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(OP_SET_PIXEL, 8'd1, 7'd1, 1'b1);
    send_item(OP_SET_PIXEL, 8'd128, 7'd64, 1'b1);
    send_item(OP_SET_PIXEL, 8'd0, 7'd10, 1'b1);
    send_item(OP_SET_PIXEL, 8'd129, 7'd10, 1'b1);
    send_item(OP_SET_PIXEL, 8'd255, 7'd127, 1'b1);
    send_item(OP_SET_PIXEL, 8'd10, 7'd0, 1'b1);
    send_item(OP_SET_PIXEL, 8'd10, 7'd65, 1'b1);
    send_item(OP_SET_PIXEL, 8'd64, 7'd8, 1'b1);
    send_item(OP_SET_PIXEL, 8'd65, 7'd9, 1'b1);
    send_item(OP_SET_PIXEL, 8'd1, 7'd1, 1'b0);
    send_flush();
    send_flush();
    // dirtied behind the scan: skipped, then wiped by done
    send_item(OP_SET_PIXEL, 8'd2, 7'd1, 1'b1);
    send_flush();
    send_flush();
    send_flush();
    send_flush();
    send_item(OP_SET_PIXEL, 8'd3, 7'd3, 1'b1);
    send_item(OP_CLEAR, 8'd0, 7'd0, 1'b0);
    send_flush();
    send_flush();
    drain_to_done();

    while (items_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 62) begin
        n  = $urandom_range(1, 8);
        bx = $urandom_range(1, COLS);
        by = $urandom_range(1, ROWS);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 6) == 0)
            send_item(OP_SET_PIXEL, 8'($urandom), 7'($urandom), 1'($urandom));
          else
            send_item(OP_SET_PIXEL, 8'(near(bx, 2, COLS)), 7'(near(by, 9, ROWS)),
                      1'($urandom));
          if ($urandom_range(0, 11) == 0)
            send_item(OP_CLEAR, 8'($urandom), 7'($urandom), 1'($urandom));
        end
        cnt = board.flushes_to_done();
        if ($urandom_range(0, 3) == 0) cnt = $urandom_range(1, cnt);
        repeat (cnt) send_flush();
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0, 1, 2: send_item(OP_SET_PIXEL, 8'($urandom), 7'($urandom), 1'($urandom));
            3, 4:    send_flush();
            default: send_item(OP_CLEAR, 8'($urandom), 7'($urandom), 1'($urandom));
          endcase
        end
      end
    end

    // fill last: every byte dirty, only a few of them flushed
    send_item(OP_FILL, 8'($urandom), 7'($urandom), 1'($urandom));
    send_flush();
    send_item(OP_SET_PIXEL, 8'($urandom_range(1, COLS)), 7'($urandom_range(1, ROWS)),
              1'b0);
    send_flush();
    send_item(OP_CLEAR, 8'hff, 7'h7f, 1'b1);
    repeat (3) send_flush();

    start <= 1'b0;
    while (board.flush_q.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 16) @(posedge clk);
    if (board.mismatches == 0 && board.flush_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/dtfb_pkg.sv
rtl/core/dtfb_store.sv
rtl/core/dirty_tracked_lcd_framebuffer_core.sv
bench/tb.sv
